### sv/cpu8dp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8dp_pkg
// Shared types and constants of the 8-bit micro-op datapath: micro-op
// codes, cycle codes, flag positions and the register file record.
// ----------------------------------------------------------------------------
package cpu8dp_pkg;

   localparam int unsigned CMD_W   = 6;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CYCLE_W = 3;

   // status bit positions
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   // flag keep masks, the N and V mask and the sign extension byte
   localparam logic [BYTE_W-1:0] KEEP_NZ   = 8'h7D;
   localparam logic [BYTE_W-1:0] KEEP_NZC  = 8'h7C;
   localparam logic [BYTE_W-1:0] KEEP_NVZC = 8'h3C;
   localparam logic [BYTE_W-1:0] KEEP_NVZ  = 8'h3D;
   localparam logic [BYTE_W-1:0] MASK_NV   = 8'hC0;
   localparam logic [BYTE_W-1:0] SIGN_EXT  = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      OP_NOP      = 6'd0,
      OP_INC_S    = 6'd1,
      OP_INC_X    = 6'd2,
      OP_INC_Y    = 6'd3,
      OP_INC_MDR  = 6'd4,
      OP_DEC_S    = 6'd5,
      OP_DEC_X    = 6'd6,
      OP_DEC_Y    = 6'd7,
      OP_DEC_MDR  = 6'd8,
      OP_TAX      = 6'd9,
      OP_TAY      = 6'd10,
      OP_TSX      = 6'd11,
      OP_TXA      = 6'd12,
      OP_TXS      = 6'd13,
      OP_TYA      = 6'd14,
      OP_MDR_PCL  = 6'd15,
      OP_MDR_A    = 6'd16,
      OP_MDR_X    = 6'd17,
      OP_MDR_Y    = 6'd18,
      OP_CLC      = 6'd19,
      OP_CLD      = 6'd20,
      OP_CLI      = 6'd21,
      OP_CLV      = 6'd22,
      OP_SEC      = 6'd23,
      OP_SED      = 6'd24,
      OP_SEI      = 6'd25,
      OP_CMP_A    = 6'd26,
      OP_CMP_X    = 6'd27,
      OP_CMP_Y    = 6'd28,
      OP_ASL_MDR  = 6'd29,
      OP_ASL_A    = 6'd30,
      OP_LSR_MDR  = 6'd31,
      OP_LSR_A    = 6'd32,
      OP_ROL_MDR  = 6'd33,
      OP_ROL_A    = 6'd34,
      OP_ROR_MDR  = 6'd35,
      OP_ROR_A    = 6'd36,
      OP_EOR      = 6'd37,
      OP_AND      = 6'd38,
      OP_ORA      = 6'd39,
      OP_ADC      = 6'd40,
      OP_SBC      = 6'd41,
      OP_BIT      = 6'd42,
      OP_ADDRL_X  = 6'd43,
      OP_ADDRL_Y  = 6'd44,
      OP_PTRL_X   = 6'd45,
      OP_FIX_AH_X = 6'd46,
      OP_FIX_AH   = 6'd47,
      OP_FIX_PCH  = 6'd48,
      OP_BRANCH   = 6'd49,
      OP_LD_MDR   = 6'd50,
      OP_LD_ADDRL = 6'd51,
      OP_LD_ADDRH = 6'd52,
      OP_LD_PTRL  = 6'd53,
      OP_LD_PCL   = 6'd54,
      OP_LD_PCH   = 6'd55
   } op_type;

   typedef enum logic [CYCLE_W-1:0] {
      CYC_NONE      = 3'd0,
      CYC_BR_NOT    = 3'd1,
      CYC_BR_SAME   = 3'd2,
      CYC_BR_CROSS  = 3'd3,
      CYC_FIXUP     = 3'd4
   } cycle_type;

   typedef struct packed {
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] y;
      logic [BYTE_W-1:0] sp;
      logic [BYTE_W-1:0] flags;
      logic [BYTE_W-1:0] mdr;
      logic [BYTE_W-1:0] pcl;
      logic [BYTE_W-1:0] pch;
      logic [BYTE_W-1:0] addrl;
      logic [BYTE_W-1:0] addrh;
      logic [BYTE_W-1:0] ptrl;
      logic [BYTE_W-1:0] page_carry;
   } regfile_type;

endpackage

### sv/cpu8dp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8dp_req_if
// Request channel: one micro-op with its load byte and instruction byte.
// ----------------------------------------------------------------------------
interface cpu8dp_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] cmd;
   logic [7:0] load_byte;
   logic [7:0] opcode;

   modport source (output valid, output cmd, output load_byte, output opcode,
                   input ready);
   modport sink   (input valid, input cmd, input load_byte, input opcode,
                   output ready);
endinterface

### sv/cpu8dp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8dp_rsp_if
// Response channel: the register file after one micro-op plus a cycle code.
// ----------------------------------------------------------------------------
interface cpu8dp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] acc;
   logic [7:0] index_x;
   logic [7:0] index_y;
   logic [7:0] stack_ptr;
   logic [7:0] status;
   logic [7:0] data_reg;
   logic [7:0] pc_low;
   logic [7:0] pc_high;
   logic [7:0] address_low;
   logic [7:0] address_high;
   logic [7:0] pointer_low;
   logic [2:0] next_cycles;

   modport source (output valid, output acc, output index_x, output index_y,
                   output stack_ptr, output status, output data_reg,
                   output pc_low, output pc_high, output address_low,
                   output address_high, output pointer_low,
                   output next_cycles, input ready);
   modport sink   (input valid, input acc, input index_x, input index_y,
                   input stack_ptr, input status, input data_reg,
                   input pc_low, input pc_high, input address_low,
                   input address_high, input pointer_low,
                   input next_cycles, output ready);
endinterface

### sv/cpu_8bit_micro_op_datapath_unit.sv
`timescale 1ns / 1ps
// Timing: the input register loads at the accepting edge; execution then
//   writes the register file and the response register once the response
//   register is free to take the result.
// Throughput: one request per cycle, sustained, while the response side takes.
// Reset (synchronous, active high): the register file including the page carry
//   clears to zero and both pipeline stages empty.
// ----------------------------------------------------------------------------
// cpu_8bit_micro_op_datapath_unit
// Register file and ALU of an 8-bit processor data path, one micro-op per
// request, responding with the whole register file and a cycle code.
// ----------------------------------------------------------------------------
module cpu_8bit_micro_op_datapath_unit
   import cpu8dp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cpu8dp_req_if.sink   req,
   cpu8dp_rsp_if.source rsp
);

   // input stage
   logic              in_valid_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [BYTE_W-1:0] load_byte_ff;
   logic [BYTE_W-1:0] opcode_ff;

   // architectural state, updated in the execute stage
   regfile_type       rf_ff;
   regfile_type       rf_in;
   cycle_type         cycle_in;

   // response stage
   logic              out_valid_ff;
   regfile_type       out_ff;
   cycle_type         out_cycle_ff;

   logic              out_free;
   logic              exec_go;
   logic              req_take;

   // The response register frees when empty or being taken; the input stage
   // executes whenever the response register can hold its result, so a new
   // request enters every cycle while the consumer keeps up.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign exec_go   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || exec_go;
   assign req_take  = req.valid && req.ready;

   cpu8dp_alu u_alu (
      .cur       (rf_ff),
      .cmd       (cmd_ff),
      .load_byte (load_byte_ff),
      .opcode    (opcode_ff),
      .nxt       (rf_in),
      .cycle     (cycle_in)
   );

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rf_ff        <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (exec_go) begin
            rf_ff <= rf_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff       <= req.cmd;
         load_byte_ff <= req.load_byte;
         opcode_ff    <= req.opcode;
      end
      if (exec_go) begin
         out_ff       <= rf_in;
         out_cycle_ff <= cycle_in;
      end
   end

   // response fields; the page carry helper stays internal
   assign rsp.valid        = out_valid_ff;
   assign rsp.acc          = out_ff.acc;
   assign rsp.index_x      = out_ff.x;
   assign rsp.index_y      = out_ff.y;
   assign rsp.stack_ptr    = out_ff.sp;
   assign rsp.status       = out_ff.flags;
   assign rsp.data_reg     = out_ff.mdr;
   assign rsp.pc_low       = out_ff.pcl;
   assign rsp.pc_high      = out_ff.pch;
   assign rsp.address_low  = out_ff.addrl;
   assign rsp.address_high = out_ff.addrh;
   assign rsp.pointer_low  = out_ff.ptrl;
   assign rsp.next_cycles  = out_cycle_ff;

endmodule

### sv/cpu8dp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8dp_alu
// Combinational execute stage: current register file and one micro-op in,
// next register file and cycle code out.
// ----------------------------------------------------------------------------
module cpu8dp_alu
   import cpu8dp_pkg::*;
(
   input  regfile_type       cur,
   input  logic [CMD_W-1:0]  cmd,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic [BYTE_W-1:0] opcode,
   output regfile_type       nxt,
   output cycle_type         cycle
);

   function automatic logic [BYTE_W-1:0] with_nz(input logic [BYTE_W-1:0] f,
                                                 input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      r         = f & KEEP_NZ;
      r[FLAG_N] = v[BYTE_W-1];
      r[FLAG_Z] = (v == '0);
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] with_nzc(input logic [BYTE_W-1:0] f,
                                                  input logic [BYTE_W-1:0] v,
                                                  input logic c);
      logic [BYTE_W-1:0] r;
      r         = f & KEEP_NZC;
      r[FLAG_N] = v[BYTE_W-1];
      r[FLAG_Z] = (v == '0);
      r[FLAG_C] = c;
      return r;
   endfunction

   op_type            op;
   logic              c_in;
   logic [BYTE_W-1:0] cmp_src;
   logic [BYTE_W:0]   cmp_diff;
   logic [BYTE_W-1:0] add_opnd;
   logic [BYTE_W:0]   add_sum;
   logic              add_ovf;
   logic [BYTE_W-1:0] sh_src;
   logic              sh_fill;
   logic [BYTE_W-1:0] shl_val;
   logic [BYTE_W-1:0] shr_val;
   logic [BYTE_W-1:0] idx_opnd;
   logic [BYTE_W:0]   idx_sum;
   logic [BYTE_W:0]   br_sum;
   logic [BYTE_W-1:0] br_carry;
   logic              br_flag;
   logic [BYTE_W-1:0] logic_val;

   assign op   = op_type'(cmd);
   assign c_in = cur.flags[FLAG_C];

   always_comb begin
      case (op)
         OP_CMP_X: cmp_src = cur.x;
         OP_CMP_Y: cmp_src = cur.y;
         default:  cmp_src = cur.acc;
      endcase
   end
   assign cmp_diff = {1'b0, cmp_src} - {1'b0, cur.mdr};

   // SBC is ADC of the complemented operand
   assign add_opnd = (op == OP_SBC) ? ~cur.mdr : cur.mdr;
   assign add_sum  = {1'b0, cur.acc} + {1'b0, add_opnd} + {{BYTE_W{1'b0}}, c_in};
   assign add_ovf  = ~(cur.acc[BYTE_W-1] ^ add_opnd[BYTE_W-1])
                     & (cur.acc[BYTE_W-1] ^ add_sum[BYTE_W-1]);

   always_comb begin
      case (op)
         OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: sh_src = cur.acc;
         default:                                sh_src = cur.mdr;
      endcase
      case (op)
         OP_ROL_MDR, OP_ROL_A, OP_ROR_MDR, OP_ROR_A: sh_fill = c_in;
         default:                                    sh_fill = 1'b0;
      endcase
   end
   assign shl_val = {sh_src[BYTE_W-2:0], sh_fill};
   assign shr_val = {sh_fill, sh_src[BYTE_W-1:1]};

   assign idx_opnd = (op == OP_ADDRL_Y) ? cur.y : cur.x;
   assign idx_sum  = {1'b0, cur.addrl} + {1'b0, idx_opnd};

   // relative branch: high-byte adjustment is carry plus offset sign
   assign br_sum   = {1'b0, cur.pcl} + {1'b0, cur.mdr};
   assign br_carry = {{(BYTE_W-1){1'b0}}, br_sum[BYTE_W]}
                     + (cur.mdr[BYTE_W-1] ? SIGN_EXT : '0);

   // opcode bits 7..6 pick N, V, C or Z
   always_comb begin
      case (opcode[7:6])
         2'd0:    br_flag = cur.flags[FLAG_N];
         2'd1:    br_flag = cur.flags[FLAG_V];
         2'd2:    br_flag = cur.flags[FLAG_C];
         default: br_flag = cur.flags[FLAG_Z];
      endcase
   end

   always_comb begin
      case (op)
         OP_EOR:  logic_val = cur.acc ^ cur.mdr;
         OP_AND:  logic_val = cur.acc & cur.mdr;
         default: logic_val = cur.acc | cur.mdr;
      endcase
   end

   always_comb begin
      nxt   = cur;
      cycle = CYC_NONE;
      case (op)
         OP_INC_S:   nxt.sp = cur.sp + 8'd1;
         OP_INC_X: begin
            nxt.x     = cur.x + 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.x);
         end
         OP_INC_Y: begin
            nxt.y     = cur.y + 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.y);
         end
         OP_INC_MDR: begin
            nxt.mdr   = cur.mdr + 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.mdr);
         end
         OP_DEC_S:   nxt.sp = cur.sp - 8'd1;
         OP_DEC_X: begin
            nxt.x     = cur.x - 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.x);
         end
         OP_DEC_Y: begin
            nxt.y     = cur.y - 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.y);
         end
         OP_DEC_MDR: begin
            nxt.mdr   = cur.mdr - 8'd1;
            nxt.flags = with_nz(cur.flags, nxt.mdr);
         end
         OP_TAX: begin
            nxt.x     = cur.acc;
            nxt.flags = with_nz(cur.flags, cur.acc);
         end
         OP_TAY: begin
            nxt.y     = cur.acc;
            nxt.flags = with_nz(cur.flags, cur.acc);
         end
         OP_TSX: begin
            nxt.x     = cur.sp;
            nxt.flags = with_nz(cur.flags, cur.sp);
         end
         OP_TXA: begin
            nxt.acc   = cur.x;
            nxt.flags = with_nz(cur.flags, cur.x);
         end
         OP_TXS:     nxt.sp = cur.x;
         OP_TYA: begin
            nxt.acc   = cur.y;
            nxt.flags = with_nz(cur.flags, cur.y);
         end
         OP_MDR_PCL: nxt.pcl = cur.mdr;
         OP_MDR_A: begin
            nxt.acc   = cur.mdr;
            nxt.flags = with_nz(cur.flags, cur.mdr);
         end
         OP_MDR_X: begin
            nxt.x     = cur.mdr;
            nxt.flags = with_nz(cur.flags, cur.mdr);
         end
         OP_MDR_Y: begin
            nxt.y     = cur.mdr;
            nxt.flags = with_nz(cur.flags, cur.mdr);
         end
         OP_CLC:     nxt.flags[FLAG_C] = 1'b0;
         OP_CLD:     nxt.flags[FLAG_D] = 1'b0;
         OP_CLI:     nxt.flags[FLAG_I] = 1'b0;
         OP_CLV:     nxt.flags[FLAG_V] = 1'b0;
         OP_SEC:     nxt.flags[FLAG_C] = 1'b1;
         OP_SED:     nxt.flags[FLAG_D] = 1'b1;
         OP_SEI:     nxt.flags[FLAG_I] = 1'b1;
         OP_CMP_A, OP_CMP_X, OP_CMP_Y:
            nxt.flags = with_nzc(cur.flags, cmp_diff[BYTE_W-1:0], ~cmp_diff[BYTE_W]);
         OP_ASL_MDR, OP_ROL_MDR: begin
            nxt.mdr   = shl_val;
            nxt.flags = with_nzc(cur.flags, shl_val, sh_src[BYTE_W-1]);
         end
         OP_ASL_A, OP_ROL_A: begin
            nxt.acc   = shl_val;
            nxt.flags = with_nzc(cur.flags, shl_val, sh_src[BYTE_W-1]);
         end
         OP_LSR_MDR, OP_ROR_MDR: begin
            nxt.mdr   = shr_val;
            nxt.flags = with_nzc(cur.flags, shr_val, sh_src[0]);
         end
         OP_LSR_A, OP_ROR_A: begin
            nxt.acc   = shr_val;
            nxt.flags = with_nzc(cur.flags, shr_val, sh_src[0]);
         end
         OP_EOR, OP_AND, OP_ORA: begin
            nxt.acc   = logic_val;
            nxt.flags = with_nz(cur.flags, logic_val);
         end
         OP_ADC, OP_SBC: begin
            nxt.acc           = add_sum[BYTE_W-1:0];
            nxt.flags         = cur.flags & KEEP_NVZC;
            nxt.flags[FLAG_N] = add_sum[BYTE_W-1];
            nxt.flags[FLAG_V] = add_ovf;
            nxt.flags[FLAG_Z] = (add_sum[BYTE_W-1:0] == '0);
            nxt.flags[FLAG_C] = add_sum[BYTE_W];
         end
         OP_BIT: begin
            nxt.flags         = (cur.flags & KEEP_NVZ) | (cur.mdr & MASK_NV);
            nxt.flags[FLAG_Z] = ((cur.acc & cur.mdr) == '0);
         end
         OP_ADDRL_X, OP_ADDRL_Y: begin
            nxt.addrl      = idx_sum[BYTE_W-1:0];
            nxt.page_carry = {{(BYTE_W-1){1'b0}}, idx_sum[BYTE_W]};
         end
         OP_PTRL_X:  nxt.ptrl = cur.ptrl + cur.x;
         OP_FIX_AH_X: begin
            if (cur.page_carry != '0) begin
               nxt.addrh = cur.addrh + cur.page_carry;
               cycle     = CYC_FIXUP;
            end
         end
         OP_FIX_AH:  nxt.addrh = cur.addrh + cur.page_carry;
         OP_FIX_PCH: nxt.pch   = cur.pch + cur.page_carry;
         OP_BRANCH: begin
            nxt.page_carry = br_carry;
            if (br_flag != opcode[5]) begin
               cycle = CYC_BR_NOT;
            end else begin
               nxt.pcl = br_sum[BYTE_W-1:0];
               cycle   = (br_carry != '0) ? CYC_BR_CROSS : CYC_BR_SAME;
            end
         end
         OP_LD_MDR:   nxt.mdr   = load_byte;
         OP_LD_ADDRL: nxt.addrl = load_byte;
         OP_LD_ADDRH: nxt.addrh = load_byte;
         OP_LD_PTRL:  nxt.ptrl  = load_byte;
         OP_LD_PCL:   nxt.pcl   = load_byte;
         OP_LD_PCH:   nxt.pch   = load_byte;
         default: begin
            nxt   = cur;
            cycle = CYC_NONE;
         end
      endcase
   end

endmodule
